### rtl/periodic_task_tick_scheduler_assert.svh
// Assertion macros used by the scheduler's port checker.
`ifndef PERIODIC_TASK_TICK_SCHEDULER_ASSERT_SVH
`define PERIODIC_TASK_TICK_SCHEDULER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define PTTS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ptts: check failed");

// Consequent checked in the cycle after the antecedent.
`define PTTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ptts: check failed");

`endif

### rtl/ptts_pkg.sv
// Shared types and constants of the periodic task tick scheduler.
package ptts_pkg;

  typedef enum logic [2:0] {
    REQ_TICK     = 3'd0,
    REQ_DISPATCH = 3'd1,
    REQ_REPORT   = 3'd2,
    REQ_STEP     = 3'd3,
    REQ_SETUP    = 3'd4
  } ptts_req_t;

  typedef enum logic [1:0] {
    KIND_RUN  = 2'd0,
    KIND_ACK  = 2'd1,
    KIND_NONE = 2'd2
  } ptts_kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TICK,
    S_DISP,
    S_ACK
  } ptts_state_t;

  typedef struct packed {
    logic live;
    logic reload;
  } ptts_alu_flags_t;

  localparam int          ADDR_W         = 3;
  localparam int          DATA_W         = 32;
  localparam logic [6:0]  TASK_COUNT_RST = 7'd0;
  localparam logic [5:0]  FIRST_STEP_RST = 6'd5;
  localparam logic [15:0] DONE_CODE      = 16'd1;

endpackage

### rtl/periodic_task_tick_scheduler.sv
// Periodic task tick scheduler top level: sequencer, slot flags and config registers.
//
//  channel | direction | handshake              | payload
//  in_     | sink      | in_tvalid / in_tready  | in_tuser request type, in_tdata slot fields
//  out_    | source    | out_tvalid / out_tready| out_tdata result fields, out_tlast
//  cfg_    | apb slave | psel, penable, pready  | task_count at 0x0, first_step at 0x4
//
// With n = task_count clamped to MAX_TASKS, a tick passes from the request cycle through the
// n slots, one slot a cycle through the slot memory read port and the shared countdown unit,
// then a write-back cycle, a closing cycle and the acknowledge. A dispatch scans the n slots
// and emits its run results; report, step, setup and unknown requests go straight to the
// acknowledge. A due result waits while the output register is full and untaken.
// Synchronous active-low reset clears all slot state; the output register holds a result.
module periodic_task_tick_scheduler #(
  parameter int MAX_TASKS  = 64,
  parameter int TIMER_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [23:0]                  in_tdata,   // task_index[5:0], value[21:6], enable[22]
  input  logic [2:0]                   in_tuser,   // req_type[2:0]
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [15:0]                  out_tdata,  // kind[1:0], run_index[7:2], step[13:8]
  output logic                         out_tlast,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [ptts_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [ptts_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [ptts_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                         cfg_pready
);

  localparam int IDX_W = $clog2(MAX_TASKS);
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int MEM_W = 2 * TIMER_BITS;

  ptts_pkg::ptts_state_t     state_r, state_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      pend_r, pend_nxt;
  logic [IDX_W-1:0]          pend_idx_r, pend_idx_nxt;
  logic [5:0]                cs_r, cs_nxt;
  logic [MAX_TASKS-1:0]      ready_r, ready_nxt;
  logic [MAX_TASKS-1:0]      en_r, en_nxt;
  logic [MAX_TASKS-1:0]      done_r, done_nxt;
  logic [6:0]                task_count_r;
  logic [5:0]                first_step_r;

  logic                      out_valid_r;
  ptts_pkg::ptts_kind_t      out_kind_r;
  logic [5:0]                out_run_r;
  logic [5:0]                out_step_r;
  logic                      out_last_r;

  logic                      in_acc;
  logic                      cfg_wr;
  logic                      out_free;
  logic [CNT_W-1:0]          lim;
  logic                      scan_on;
  logic [IDX_W-1:0]          ci;
  logic [IDX_W-1:0]          tidx;
  logic                      tidx_ok;
  logic [IDX_W-1:0]          sidx;
  logic                      sidx_ok;
  logic [6:0]                cs_adv;
  logic [TIMER_BITS-1:0]     in_val;

  logic                      emit;
  ptts_pkg::ptts_kind_t      emit_kind;
  logic [IDX_W-1:0]          emit_run;
  logic                      emit_last;

  logic                      ram_we;
  logic [IDX_W-1:0]          ram_wa;
  logic [MEM_W-1:0]          ram_wd;
  logic                      ram_re;
  logic [MEM_W-1:0]          ram_rd;
  logic [TIMER_BITS-1:0]     alu_cd;
  ptts_pkg::ptts_alu_flags_t alu_flags;

  ptts_slot_ram #(
    .DEPTH  (MAX_TASKS),
    .WIDTH  (MEM_W),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_en   (ram_re),
    .rd_addr (ci),
    .rd_data (ram_rd)
  );

  ptts_slot_alu #(
    .TIMER_BITS (TIMER_BITS)
  ) u_alu (
    .cd_i    (ram_rd[TIMER_BITS-1:0]),
    .iv_i    (ram_rd[MEM_W-1:TIMER_BITS]),
    .cd_o    (alu_cd),
    .flags_o (alu_flags)
  );

  assign in_tready  = (state_r == ptts_pkg::S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = cfg_paddr[2] ? ptts_pkg::DATA_W'(first_step_r)
                                   : ptts_pkg::DATA_W'(task_count_r);
  assign out_free   = !out_valid_r || out_tready;

  assign lim     = (32'(task_count_r) < 32'(MAX_TASKS)) ? CNT_W'(task_count_r)
                                                        : CNT_W'(MAX_TASKS);
  assign scan_on = (cnt_r < lim);
  assign ci      = cnt_r[IDX_W-1:0];
  assign tidx    = IDX_W'(in_tdata[5:0]);
  assign tidx_ok = (32'(in_tdata[5:0]) < 32'(MAX_TASKS));
  assign sidx    = IDX_W'(cs_r);
  assign sidx_ok = (32'(cs_r) < 32'(MAX_TASKS));
  assign in_val  = TIMER_BITS'(in_tdata[21:6]);
  assign cs_adv  = {1'b0, cs_r} + 7'(sidx_ok && done_r[sidx]);

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    pend_nxt     = pend_r;
    pend_idx_nxt = pend_idx_r;
    cs_nxt       = cs_r;
    ready_nxt    = ready_r;
    en_nxt       = en_r;
    done_nxt     = done_r;
    emit         = 1'b0;
    emit_kind    = ptts_pkg::KIND_ACK;
    emit_run     = '0;
    emit_last    = 1'b1;
    ram_we       = 1'b0;
    ram_wa       = pend_idx_r;
    ram_wd       = {ram_rd[MEM_W-1:TIMER_BITS], alu_cd};
    ram_re       = 1'b0;

    // Writing first_step restarts the foreground sequence
    if (cfg_wr && cfg_paddr[2]) begin
      cs_nxt = cfg_pwdata[5:0];
    end

    unique case (state_r)
      ptts_pkg::S_IDLE: begin
        if (in_acc) begin
          cnt_nxt  = '0;
          pend_nxt = 1'b0;
          unique case (in_tuser)
            ptts_pkg::REQ_TICK: begin
              state_nxt = ptts_pkg::S_TICK;
            end
            ptts_pkg::REQ_DISPATCH: begin
              state_nxt = ptts_pkg::S_DISP;
            end
            ptts_pkg::REQ_REPORT: begin
              if (tidx_ok) begin
                done_nxt[tidx] = (in_tdata[21:6] == ptts_pkg::DONE_CODE);
              end
              state_nxt = ptts_pkg::S_ACK;
            end
            ptts_pkg::REQ_STEP: begin
              // Enable the step slot, or retire it once done, then clamp
              if (sidx_ok) begin
                en_nxt[sidx] = !done_r[sidx];
              end
              if (lim == '0) begin
                cs_nxt = '0;
              end else if (32'(cs_adv) >= 32'(lim)) begin
                cs_nxt = 6'(lim - CNT_W'(1));
              end else begin
                cs_nxt = cs_adv[5:0];
              end
              state_nxt = ptts_pkg::S_ACK;
            end
            ptts_pkg::REQ_SETUP: begin
              if (tidx_ok) begin
                ram_we       = 1'b1;
                ram_wa       = tidx;
                ram_wd       = {in_val, in_val};
                en_nxt[tidx] = in_tdata[22];
              end
              state_nxt = ptts_pkg::S_ACK;
            end
            default: begin
              state_nxt = ptts_pkg::S_ACK;
            end
          endcase
        end
      end

      ptts_pkg::S_TICK: begin
        // Read slot cnt while writing back the slot read in the previous cycle
        if (scan_on) begin
          ram_re  = 1'b1;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        pend_nxt     = scan_on;
        pend_idx_nxt = ci;
        if (pend_r) begin
          ram_we = alu_flags.live;
          if (alu_flags.reload) begin
            ready_nxt[pend_idx_r] = 1'b1;
          end
        end
        if (!scan_on && !pend_r) begin
          state_nxt = ptts_pkg::S_ACK;
        end
      end

      ptts_pkg::S_DISP: begin
        // Hold one hit back so the final run result can carry tlast
        if (scan_on) begin
          if (ready_r[ci] && en_r[ci]) begin
            if (pend_r) begin
              if (out_free) begin
                emit          = 1'b1;
                emit_kind     = ptts_pkg::KIND_RUN;
                emit_run      = pend_idx_r;
                emit_last     = 1'b0;
                pend_idx_nxt  = ci;
                ready_nxt[ci] = 1'b0;
                cnt_nxt       = cnt_r + CNT_W'(1);
              end
            end else begin
              pend_nxt      = 1'b1;
              pend_idx_nxt  = ci;
              ready_nxt[ci] = 1'b0;
              cnt_nxt       = cnt_r + CNT_W'(1);
            end
          end else begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end else if (out_free) begin
          emit      = 1'b1;
          emit_kind = pend_r ? ptts_pkg::KIND_RUN : ptts_pkg::KIND_NONE;
          emit_run  = pend_r ? pend_idx_r : '0;
          emit_last = 1'b1;
          pend_nxt  = 1'b0;
          state_nxt = ptts_pkg::S_IDLE;
        end
      end

      ptts_pkg::S_ACK: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = ptts_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = ptts_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ptts_pkg::S_IDLE;
      cnt_r        <= '0;
      pend_r       <= 1'b0;
      pend_idx_r   <= '0;
      cs_r         <= ptts_pkg::FIRST_STEP_RST;
      ready_r      <= '0;
      en_r         <= '0;
      done_r       <= '0;
      task_count_r <= ptts_pkg::TASK_COUNT_RST;
      first_step_r <= ptts_pkg::FIRST_STEP_RST;
      out_valid_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      pend_r     <= pend_nxt;
      pend_idx_r <= pend_idx_nxt;
      cs_r       <= cs_nxt;
      ready_r    <= ready_nxt;
      en_r       <= en_nxt;
      done_r     <= done_nxt;
      if (cfg_wr) begin
        if (cfg_paddr[2]) begin
          first_step_r <= cfg_pwdata[5:0];
        end else begin
          task_count_r <= cfg_pwdata[6:0];
        end
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload; step is taken after the request's own update
  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r <= emit_kind;
      out_run_r  <= 6'(emit_run);
      out_step_r <= cs_r;
      out_last_r <= emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_step_r, out_run_r, out_kind_r};
  assign out_tlast  = out_last_r;

endmodule

### rtl/ptts_slot_ram.sv
// Slot timer memory: interval and countdown per slot, with per-entry valid bits.
module ptts_slot_ram #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [WIDTH-1:0] rd_data_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // An entry never written reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

### rtl/ptts_slot_alu.sv
// Countdown unit: decrement a live countdown and reload it on expiry.
module ptts_slot_alu #(
  parameter int TIMER_BITS = 16
) (
  input  logic [TIMER_BITS-1:0]     cd_i,
  input  logic [TIMER_BITS-1:0]     iv_i,
  output logic [TIMER_BITS-1:0]     cd_o,
  output ptts_pkg::ptts_alu_flags_t flags_o
);

  logic [TIMER_BITS-1:0] dec;

  always_comb begin
    dec            = cd_i - TIMER_BITS'(1);
    flags_o.live   = |cd_i;
    flags_o.reload = flags_o.live && (dec == '0);
    if (!flags_o.live) begin
      cd_o = cd_i;
    end else if (flags_o.reload) begin
      cd_o = iv_i;
    end else begin
      cd_o = dec;
    end
  end

endmodule

### rtl/ptts_checker.sv
// Port-level checker for the periodic task tick scheduler, bound to the top level.
`include "periodic_task_tick_scheduler_assert.svh"

module ptts_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast
);

  `PTTS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast))
  `PTTS_ASSERT_NEXT(a_busy_after_req, in_tvalid && in_tready, !in_tready)
  `PTTS_ASSERT_SAME(a_single_is_last, out_tvalid && (out_tdata[1:0] != ptts_pkg::KIND_RUN), out_tlast)
  `PTTS_ASSERT_SAME(a_idx_zero, out_tvalid && (out_tdata[1:0] != ptts_pkg::KIND_RUN), out_tdata[7:2] == 6'd0)

endmodule

bind periodic_task_tick_scheduler ptts_checker u_ptts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

### tb/periodic_task_tick_scheduler_checker.sv
// Scoreboard for the tick scheduler: mirrors the slot table and checks every result.
module periodic_task_tick_scheduler_checker #(
  parameter logic [ptts_pkg::ADDR_W-1:0] TASK_COUNT_ADDR = '0,
  parameter logic [ptts_pkg::ADDR_W-1:0] FIRST_STEP_ADDR = '0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  input  logic [23:0]                 in_tdata,   // task_index[5:0], value[21:6], enable[22]
  input  logic [2:0]                  in_tuser,   // req_type[2:0]
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic [15:0]                 out_tdata,  // kind[1:0], run_index[7:2], step[13:8]
  input  logic                        out_tlast,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [ptts_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [ptts_pkg::DATA_W-1:0] cfg_pwdata,
  input  logic                        cfg_pready,
  output int                          error_count,
  output int                          results_outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_TASKS = 64;

  typedef struct packed {
    ptts_pkg::ptts_kind_t kind;
    logic [5:0]           run_index;
    logic [5:0]           step;
    logic                 last;
  } sched_result_t;

  logic [15:0]   slot_count  [MAX_TASKS];
  logic [15:0]   slot_period [MAX_TASKS];
  logic          slot_ready  [MAX_TASKS];
  logic          slot_run    [MAX_TASKS];
  logic          slot_done   [MAX_TASKS];
  logic [5:0]    fg_step;
  logic [6:0]    scan_len;
  logic [5:0]    seq_start;
  sched_result_t pending_runs [$];

  task automatic push_result(input ptts_pkg::ptts_kind_t kind, input logic [5:0] idx,
                             input logic last);
    sched_result_t r;
    r.kind      = kind;
    r.run_index = idx;
    r.step      = fg_step;
    r.last      = last;
    pending_runs.push_back(r);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endtask

  // Apply one request to the mirrored table and queue the results it should produce.
  task automatic advance_schedule(input logic [2:0] req, input logic [5:0] slot,
                                  input logic [15:0] val, input logic en);
    int lim;
    int hits;
    int seen;
    int nxt;
    int i;
    lim = (scan_len < MAX_TASKS) ? int'(scan_len) : MAX_TASKS;
    case (req)
      ptts_pkg::REQ_TICK: begin
        for (i = 0; i < lim; i++) begin
          if (slot_count[i] != '0) begin
            slot_count[i] = slot_count[i] - 16'd1;
            if (slot_count[i] == '0) begin
              slot_count[i] = slot_period[i];
              slot_ready[i] = 1'b1;
            end
          end
        end
      end
      ptts_pkg::REQ_DISPATCH: begin
        hits = 0;
        seen = 0;
        for (i = 0; i < lim; i++) begin
          if (slot_ready[i] && slot_run[i]) hits++;
        end
        if (hits == 0) push_result(ptts_pkg::KIND_NONE, '0, 1'b1);
        for (i = 0; i < lim; i++) begin
          if (slot_ready[i] && slot_run[i]) begin
            slot_ready[i] = 1'b0;
            seen++;
            push_result(ptts_pkg::KIND_RUN, 6'(i), seen == hits);
          end
        end
      end
      ptts_pkg::REQ_REPORT: slot_done[slot] = (val == ptts_pkg::DONE_CODE);
      ptts_pkg::REQ_STEP: begin
        nxt = int'(fg_step);
        slot_run[nxt] = 1'b1;
        if (slot_done[nxt]) begin
          nxt++;
          slot_run[nxt - 1] = 1'b0;
        end
        // clamp to the scanned range
        if (lim == 0) nxt = 0;
        else if (nxt >= lim) nxt = lim - 1;
        fg_step = 6'(nxt);
      end
      ptts_pkg::REQ_SETUP: begin
        slot_period[slot] = val;
        slot_count[slot]  = val;
        slot_run[slot]    = en;
      end
      default: ;
    endcase
    if (req != ptts_pkg::REQ_DISPATCH) push_result(ptts_pkg::KIND_ACK, '0, 1'b1);
  endtask

  always @(posedge clk) begin
    sched_result_t want;
    if (!rst_n) begin
      foreach (slot_count[i]) begin
        slot_count[i]  = '0;
        slot_period[i] = '0;
        slot_ready[i]  = 1'b0;
        slot_run[i]    = 1'b0;
        slot_done[i]   = 1'b0;
      end
      scan_len    = ptts_pkg::TASK_COUNT_RST;
      seq_start   = ptts_pkg::FIRST_STEP_RST;
      fg_step     = ptts_pkg::FIRST_STEP_RST;
      error_count = 0;
      pending_runs.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr == TASK_COUNT_ADDR) begin
          scan_len = cfg_pwdata[6:0];
        end else if (cfg_paddr == FIRST_STEP_ADDR) begin
          // restart the foreground sequence
          seq_start = cfg_pwdata[5:0];
          fg_step   = seq_start;
        end
      end
      if (in_tvalid && in_tready) begin
        advance_schedule(in_tuser, in_tdata[5:0], in_tdata[21:6], in_tdata[22]);
      end
      if (out_tvalid && out_tready) begin
        if (pending_runs.size() == 0) begin
          $error("result with no request outstanding: tdata %h, tlast %b",
                 out_tdata, out_tlast);
          error_count++;
        end else begin
          want = pending_runs.pop_front();
          check_field("kind", int'(want.kind), int'(out_tdata[1:0]));
          check_field("run_index", int'(want.run_index), int'(out_tdata[7:2]));
          check_field("step", int'(want.step), int'(out_tdata[13:8]));
          check_field("last", int'(want.last), int'(out_tlast));
        end
      end
    end
    results_outstanding <= pending_runs.size();
  end

endmodule

### tb/periodic_task_tick_scheduler_tb.sv
// Testbench top for the tick scheduler: clock, reset, request stimulus and verdict.
module periodic_task_tick_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ptts_pkg::ADDR_W-1:0] TASK_COUNT_ADDR = 3'd0;
  localparam logic [ptts_pkg::ADDR_W-1:0] FIRST_STEP_ADDR = 3'd4;
  localparam logic [2:0]                  REQ_UNDEF_LO    = 3'd5;
  localparam logic [2:0]                  REQ_UNDEF_MID   = 3'd6;
  localparam logic [2:0]                  REQ_UNDEF_HI    = 3'd7;
  localparam int                          QUIET_LIMIT     = 3000;
  localparam int                          SETTLE_CYCLES   = 100;
  localparam int                          PHASES          = 8;
  localparam int                          PHASE_REQUESTS  = 31;

  logic                        clk;
  logic                        rst_n;
  logic                        in_tvalid;
  logic                        in_tready;
  logic [23:0]                 in_tdata;   // task_index[5:0], value[21:6], enable[22]
  logic [2:0]                  in_tuser;   // req_type[2:0]
  logic                        out_tvalid;
  logic                        out_tready = 1'b0;
  logic [15:0]                 out_tdata;  // kind[1:0], run_index[7:2], step[13:8]
  logic                        out_tlast;
  logic                        cfg_psel;
  logic                        cfg_penable;
  logic                        cfg_pwrite;
  logic [ptts_pkg::ADDR_W-1:0] cfg_paddr;
  logic [ptts_pkg::DATA_W-1:0] cfg_pwdata;
  logic [ptts_pkg::DATA_W-1:0] cfg_prdata;
  logic                        cfg_pready;
  logic                        allow_gaps = 1'b0;
  int                          stall_left = 0;
  int                          quiet_cycles = 0;
  int                          error_count;
  int                          results_outstanding;

  periodic_task_tick_scheduler DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  periodic_task_tick_scheduler_checker #(
    .TASK_COUNT_ADDR (TASK_COUNT_ADDR),
    .FIRST_STEP_ADDR (FIRST_STEP_ADDR)
  ) checker_i (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_tvalid           (in_tvalid),
    .in_tready           (in_tready),
    .in_tdata            (in_tdata),
    .in_tuser            (in_tuser),
    .out_tvalid          (out_tvalid),
    .out_tready          (out_tready),
    .out_tdata           (out_tdata),
    .out_tlast           (out_tlast),
    .cfg_psel            (cfg_psel),
    .cfg_penable         (cfg_penable),
    .cfg_pwrite          (cfg_pwrite),
    .cfg_paddr           (cfg_paddr),
    .cfg_pwdata          (cfg_pwdata),
    .cfg_pready          (cfg_pready),
    .error_count         (error_count),
    .results_outstanding (results_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Stall the result side in random bursts.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (allow_gaps && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 18);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(input logic [2:0] req, input logic [5:0] idx,
                              input logic [15:0] val, input logic en);
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {1'b0, en, val, idx};
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop valid and hold until every queued result has been taken.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ptts_pkg::ADDR_W-1:0] addr,
                           input logic [ptts_pkg::DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    // idle the bus before the next transfer
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly well-formed traffic on the scanned slots, with short intervals so slots expire.
  task automatic random_request(input int lim);
    int          pick;
    logic [5:0]  idx;
    logic [15:0] val;
    logic        en;
    pick = $urandom_range(0, 99);
    idx  = (lim > 0 && $urandom_range(0, 4) != 0) ? 6'($urandom_range(0, lim - 1))
                                                  : 6'($urandom);
    val  = 16'($urandom);
    en   = 1'($urandom);
    if (pick < 28) begin
      send_request(ptts_pkg::REQ_TICK, idx, val, en);
    end else if (pick < 46) begin
      send_request(ptts_pkg::REQ_DISPATCH, idx, val, en);
    end else if (pick < 60) begin
      if ($urandom_range(0, 2) != 0) val = 16'($urandom_range(0, 1));
      send_request(ptts_pkg::REQ_REPORT, idx, val, en);
    end else if (pick < 72) begin
      send_request(ptts_pkg::REQ_STEP, idx, val, en);
    end else if (pick < 94) begin
      if ($urandom_range(0, 4) != 0) val = 16'($urandom_range(0, 6));
      en = ($urandom_range(0, 3) != 0);
      send_request(ptts_pkg::REQ_SETUP, idx, val, en);
    end else begin
      send_request(3'($urandom_range(REQ_UNDEF_LO, REQ_UNDEF_HI)), idx, val, en);
    end
  endtask

  initial begin
    int ph;
    int tc;
    int fs;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (8) @(posedge clk);
    rst_n      <= 1'b1;
    allow_gaps <= 1'b1;

    // reset configuration: nothing scanned, step clamps to zero
    send_request(ptts_pkg::REQ_TICK, '0, '0, 1'b0);
    send_request(ptts_pkg::REQ_DISPATCH, '0, '0, 1'b0);
    send_request(ptts_pkg::REQ_STEP, '0, '0, 1'b0);
    send_request(REQ_UNDEF_LO, '0, '0, 1'b0);
    send_request(REQ_UNDEF_HI, 6'h3f, 16'hffff, 1'b1);
    send_request(ptts_pkg::REQ_SETUP, '0, 16'd3, 1'b1);
    drain();

    write_reg(TASK_COUNT_ADDR, 32'd64);
    write_reg(FIRST_STEP_ADDR, 32'd62);
    send_request(ptts_pkg::REQ_SETUP, 6'd0, 16'd1, 1'b1);
    send_request(ptts_pkg::REQ_SETUP, 6'd63, 16'hffff, 1'b1);
    send_request(ptts_pkg::REQ_SETUP, 6'd1, 16'd2, 1'b0);
    send_request(ptts_pkg::REQ_SETUP, 6'd2, 16'd0, 1'b1);
    send_request(ptts_pkg::REQ_TICK, '0, '0, 1'b0);
    send_request(ptts_pkg::REQ_DISPATCH, '0, '0, 1'b0);
    send_request(ptts_pkg::REQ_TICK, '0, '0, 1'b0);
    send_request(ptts_pkg::REQ_DISPATCH, '0, '0, 1'b0);
    // walk the step onto the top slot and into the clamp
    send_request(ptts_pkg::REQ_REPORT, 6'd62, ptts_pkg::DONE_CODE, 1'b0);
    send_request(ptts_pkg::REQ_STEP, '0, '0, 1'b0);
    send_request(ptts_pkg::REQ_REPORT, 6'd63, ptts_pkg::DONE_CODE, 1'b0);
    send_request(ptts_pkg::REQ_STEP, '0, '0, 1'b0);
    send_request(ptts_pkg::REQ_REPORT, 6'd63, 16'hffff, 1'b1);
    send_request(ptts_pkg::REQ_REPORT, 6'd1, 16'd0, 1'b0);
    send_request(ptts_pkg::REQ_STEP, '0, '0, 1'b0);
    send_request(REQ_UNDEF_MID, 6'h3f, 16'hffff, 1'b1);
    send_request(ptts_pkg::REQ_DISPATCH, '0, '0, 1'b0);
    drain();

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       tc = 64;
        1:       tc = 0;
        2:       tc = 1;
        5:       tc = $urandom_range(13, 64);
        default: tc = $urandom_range(2, 12);
      endcase
      if (ph == 0) fs = 63;
      else if (ph == 1) fs = 0;
      else if ($urandom_range(0, 1) != 0) fs = $urandom_range(0, tc - 1);
      else fs = $urandom_range(0, 63);
      // keep the last phase free of gaps and stalls
      allow_gaps <= (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
      write_reg(TASK_COUNT_ADDR, ptts_pkg::DATA_W'(tc));
      write_reg(FIRST_STEP_ADDR, ptts_pkg::DATA_W'(fs));
      repeat (PHASE_REQUESTS) random_request(tc);
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
